@@ sv/pfm_pkg.sv @@
// pfm_pkg: shared widths, codes and types for the pulse flow meter unit
// no dependencies; imported by pfm_div and the top level
`timescale 1ns / 1ps

package pfm_pkg;

  localparam int NUM_SENSORS    = 2;
  localparam int IDX_W          = 1;
  localparam int CNT_W          = 2;
  localparam int MAX_DELTA_BITS = 16;
  localparam int GEN_W          = 24;
  localparam int REM_W          = 10;
  localparam int ACC_W          = 41;
  localparam int GAL_W          = 48;
  localparam int NUM_W          = 48;
  localparam int DVD_W          = 64;
  localparam int DVS_W          = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int TEMP_W         = 16;

  localparam logic signed [TEMP_W-1:0] TEMP_DEFAULT  = 16'sd2560;
  localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST  = -16'sd5120;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST  = 16'sd16000;
  localparam logic [15:0]              PPG_RST       = 16'd450;
  localparam logic [1:0]               ENABLE_RST    = 2'd3;
  localparam logic [15:0]              GEN_DIVISOR   = 16'd1000;
  localparam logic [15:0]              MS_PER_MIN    = 16'd60000;

  typedef enum logic [3:0] {
    CMD_TICK       = 4'd0,
    CMD_SET_TEMP   = 4'd1,
    CMD_SET_COUNT  = 4'd2,
    CMD_ADD_PULSES = 4'd3,
    CMD_START_GEN  = 4'd4,
    CMD_STOP_GEN   = 4'd5,
    CMD_SET_TYPE   = 4'd6,
    CMD_FAIL       = 4'd7,
    CMD_RECOVER    = 4'd8,
    CMD_RESET_FLOW = 4'd9,
    CMD_READ       = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_ZERO  = 2'd2
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_MIN_TEMP = 2'd1,
    CFG_MAX_TEMP = 2'd2,
    CFG_PPG      = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_GEN_CHK,
    ST_GEN_DIVS,
    ST_GEN_WAIT,
    ST_FLOW_CHK,
    ST_FLOW_MUL,
    ST_GAL_DIVS,
    ST_GAL_WAIT,
    ST_RATE_DIVS,
    ST_RATE_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ sv/pulse_flow_meter_with_rate_generator_unit.sv @@
// pulse flow meter unit: two sensor records, pulse generators, flow totals
// simple commands pass through dispatch to the result register; pulses on a meter run
// two serial divisions (gallons, then rate); a tick may run a generator division per present sensor
// one item at a time, limited by the shared bit-serial divider
// reset (synchronous, rst_n low) restores register defaults and clears all
// records; any configuration write also clears all records and the clock
`timescale 1ns / 1ps

module pulse_flow_meter_with_rate_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [3:0]                         in_cmd,
  input  logic                               in_sensor,
  input  logic                               in_all_sensors,
  input  logic [31:0]                        in_value,
  input  logic signed [pfm_pkg::TEMP_W-1:0]  in_temperature,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_sensor_id,
  output logic signed [pfm_pkg::TEMP_W-1:0]  out_temp_out,
  output logic                               out_valid_res,
  output logic                               out_is_meter,
  output logic [31:0]                        out_pulse_total,
  output logic [31:0]                        out_flow_rate,
  output logic [pfm_pkg::GAL_W-1:0]          out_total_gallons,
  output logic [31:0]                        out_update_time,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pfm_pkg::*;

  state_t state_r, state_nxt;

  // configuration
  logic [1:0]               en_r;
  logic signed [TEMP_W-1:0] min_r, max_r;
  logic [15:0]              ppg_r;

  // records
  logic [31:0]              now_r;
  logic signed [TEMP_W-1:0] temp_r  [NUM_SENSORS];
  logic                     vld_r   [NUM_SENSORS];
  logic                     mtr_r   [NUM_SENSORS];
  logic [31:0]              pls_r   [NUM_SENSORS];
  logic [31:0]              rate_r  [NUM_SENSORS];
  logic [GAL_W-1:0]         gal_r   [NUM_SENSORS];
  logic [31:0]              stamp_r [NUM_SENSORS];
  logic                     gact_r  [NUM_SENSORS];
  logic [GEN_W-1:0]         grate_r [NUM_SENSORS];
  logic [REM_W-1:0]         mrem_r  [NUM_SENSORS];
  logic [31:0]              rcnt_r  [NUM_SENSORS];
  logic [31:0]              rtime_r [NUM_SENSORS];

  // item and work registers
  cmd_t                     cmd_r;
  logic                     sens_r;
  logic                     all_r;
  logic [31:0]              val_r;
  logic signed [TEMP_W-1:0] tin_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     multi_r;
  stat_t                    kind_r;
  logic [MAX_DELTA_BITS-1:0] delta_r;
  logic [ACC_W-1:0]         acc_r;
  logic [31:0]              d_r;
  logic [31:0]              el_r;
  logic [NUM_W-1:0]         num_r;
  logic [NUM_W-1:0]         den_r;

  // result register
  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic                     out_sensor_id_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic                     out_vres_r;
  logic                     out_meter_r;
  logic [31:0]              out_pulse_r;
  logic [31:0]              out_rate_r;
  logic [GAL_W-1:0]         out_gal_r;
  logic [31:0]              out_time_r;
  logic                     out_last_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CNT_W-1:0]          n_cnt;
  logic                      sens_ok;
  logic                      last_sensor;
  logic                      out_free;
  logic                      out_load;
  logic [MAX_DELTA_BITS-1:0] delta_sat;
  logic signed [TEMP_W-1:0]  t_hi, t_clamp;
  logic [31:0]               elapsed;
  logic [GAL_W:0]            gal_sum;
  logic                      tick_go;

  pfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // shared decode
  always_comb begin
    n_cnt       = CNT_W'(en_r[0]) + CNT_W'(en_r[1]);
    sens_ok     = (CNT_W'(sens_r) < n_cnt);
    last_sensor = ((CNT_W'(idx_r) + CNT_W'(1)) == n_cnt);
    out_free    = !out_valid_r || !out_stall;
    delta_sat   = (|val_r[31:MAX_DELTA_BITS]) ? '1 : val_r[MAX_DELTA_BITS-1:0];
    t_hi        = (tin_r > max_r) ? max_r : tin_r;
    t_clamp     = (t_hi < min_r) ? min_r : t_hi;
    elapsed     = now_r - rtime_r[idx_r];
    gal_sum     = {1'b0, gal_r[idx_r]} + {1'b0, div_rsp.quotient[GAL_W-1:0]};
    tick_go     = (val_r != '0) && (n_cnt != '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        if (cmd_r == CMD_TICK) begin
          state_nxt = tick_go ? ST_GEN_CHK : ST_EMIT;
        end else if (cmd_r == CMD_RESET_FLOW && all_r) begin
          state_nxt = ST_EMIT;
        end else if (cmd_r == CMD_ADD_PULSES && sens_ok) begin
          state_nxt = ST_FLOW_CHK;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_GEN_CHK:  state_nxt = gact_r[idx_r] ? ST_GEN_DIVS : ST_EMIT;
      ST_GEN_DIVS: state_nxt = ST_GEN_WAIT;
      ST_GEN_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = (div_rsp.quotient != '0) ? ST_FLOW_CHK : ST_EMIT;
        end
      end
      ST_FLOW_CHK: begin
        if (!mtr_r[idx_r] || ppg_r == '0 || elapsed == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_FLOW_MUL;
        end
      end
      ST_FLOW_MUL:  state_nxt = ST_GAL_DIVS;
      ST_GAL_DIVS:  state_nxt = ST_GAL_WAIT;
      ST_GAL_WAIT:  if (div_rsp.done) state_nxt = ST_RATE_DIVS;
      ST_RATE_DIVS: state_nxt = ST_RATE_WAIT;
      ST_RATE_WAIT: if (div_rsp.done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (multi_r && kind_r == STAT_DONE && !last_sensor) begin
            state_nxt = (cmd_r == CMD_TICK) ? ST_GEN_CHK : ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs and divider operand select
  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    out_load     = (state_r == ST_EMIT) && out_free;
    div_req      = '0;
    unique case (state_r)
      ST_GEN_DIVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(acc_r);
        div_req.divisor  = DVS_W'(GEN_DIVISOR);
      end
      ST_GAL_DIVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'({d_r, 16'd0});
        div_req.divisor  = DVS_W'(ppg_r);
      end
      ST_RATE_DIVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {num_r, 16'd0};
        div_req.divisor  = den_r;
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration and record state
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      if (!rst_n) begin
        en_r  <= ENABLE_RST;
        min_r <= MIN_TEMP_RST;
        max_r <= MAX_TEMP_RST;
        ppg_r <= PPG_RST;
      end else begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:   en_r  <= cfg_wdata[1:0];
          CFG_MIN_TEMP: min_r <= $signed(cfg_wdata);
          CFG_MAX_TEMP: max_r <= $signed(cfg_wdata);
          CFG_PPG:      ppg_r <= cfg_wdata;
          default:      en_r  <= en_r;
        endcase
      end
      now_r <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        temp_r[i]  <= TEMP_DEFAULT;
        vld_r[i]   <= 1'b1;
        mtr_r[i]   <= 1'b0;
        pls_r[i]   <= '0;
        rate_r[i]  <= '0;
        gal_r[i]   <= '0;
        stamp_r[i] <= '0;
        gact_r[i]  <= 1'b0;
        grate_r[i] <= '0;
        mrem_r[i]  <= '0;
        rcnt_r[i]  <= '0;
        rtime_r[i] <= '0;
      end
    end else begin
      case (state_r)
        ST_DISPATCH: begin
          if (cmd_r == CMD_TICK) begin
            if (val_r != '0) now_r <= now_r + 32'(delta_sat);
          end else if (cmd_r == CMD_RESET_FLOW && all_r) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
              if (CNT_W'(i) < n_cnt) begin
                rate_r[i]  <= '0;
                gal_r[i]   <= '0;
                rcnt_r[i]  <= pls_r[i];
                rtime_r[i] <= now_r;
              end
            end
          end else if (sens_ok) begin
            case (cmd_r)
              CMD_SET_TEMP: begin
                temp_r[sens_r]  <= t_clamp;
                stamp_r[sens_r] <= now_r;
              end
              CMD_SET_COUNT: begin
                pls_r[sens_r]   <= val_r;
                stamp_r[sens_r] <= now_r;
                rcnt_r[sens_r]  <= val_r;
                rtime_r[sens_r] <= now_r;
                rate_r[sens_r]  <= '0;
              end
              CMD_ADD_PULSES: begin
                pls_r[sens_r]   <= pls_r[sens_r] + val_r;
                stamp_r[sens_r] <= now_r;
              end
              CMD_START_GEN: begin
                gact_r[sens_r]  <= 1'b1;
                grate_r[sens_r] <= (|val_r[31:GEN_W]) ? '1 : val_r[GEN_W-1:0];
              end
              CMD_STOP_GEN: begin
                gact_r[sens_r]  <= 1'b0;
                grate_r[sens_r] <= '0;
                mrem_r[sens_r]  <= '0;
              end
              CMD_SET_TYPE: begin
                mtr_r[sens_r]   <= (val_r != '0);
                stamp_r[sens_r] <= now_r;
              end
              CMD_FAIL: begin
                vld_r[sens_r]   <= 1'b0;
                stamp_r[sens_r] <= now_r;
              end
              CMD_RECOVER: begin
                vld_r[sens_r]   <= 1'b1;
                stamp_r[sens_r] <= now_r;
              end
              CMD_RESET_FLOW: begin
                rate_r[sens_r]  <= '0;
                gal_r[sens_r]   <= '0;
                rcnt_r[sens_r]  <= pls_r[sens_r];
                rtime_r[sens_r] <= now_r;
              end
              default: stamp_r[sens_r] <= stamp_r[sens_r];
            endcase
          end
        end
        ST_GEN_WAIT: begin
          if (div_rsp.done) begin
            mrem_r[idx_r] <= div_rsp.remainder[REM_W-1:0];
            if (div_rsp.quotient != '0) begin
              pls_r[idx_r]   <= pls_r[idx_r] + div_rsp.quotient[31:0];
              stamp_r[idx_r] <= now_r;
            end
          end
        end
        ST_FLOW_CHK: begin
          if (mtr_r[idx_r] && ppg_r == '0) rate_r[idx_r] <= '0;
        end
        ST_GAL_WAIT: begin
          if (div_rsp.done) begin
            gal_r[idx_r] <= gal_sum[GAL_W] ? '1 : gal_sum[GAL_W-1:0];
          end
        end
        ST_RATE_WAIT: begin
          if (div_rsp.done) begin
            rate_r[idx_r]  <= (|div_rsp.quotient[DVD_W-1:32]) ? '1 : div_rsp.quotient[31:0];
            rcnt_r[idx_r]  <= pls_r[idx_r];
            rtime_r[idx_r] <= now_r;
          end
        end
        default: now_r <= now_r;
      endcase
    end
  end

  // item capture and work registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r  <= cmd_t'(in_cmd);
      sens_r <= in_sensor;
      all_r  <= in_all_sensors;
      val_r  <= in_value;
      tin_r  <= in_temperature;
    end
    case (state_r)
      ST_DISPATCH: begin
        delta_r <= delta_sat;
        if (cmd_r == CMD_TICK) begin
          idx_r   <= '0;
          multi_r <= 1'b1;
          if (val_r == '0) begin
            kind_r  <= STAT_ZERO;
            multi_r <= 1'b0;
          end else begin
            kind_r  <= (n_cnt == '0) ? STAT_RANGE : STAT_DONE;
          end
        end else if (cmd_r == CMD_RESET_FLOW && all_r) begin
          idx_r   <= '0;
          multi_r <= 1'b1;
          kind_r  <= (n_cnt == '0) ? STAT_RANGE : STAT_DONE;
        end else begin
          idx_r   <= sens_r;
          multi_r <= 1'b0;
          kind_r  <= sens_ok ? STAT_DONE : STAT_RANGE;
        end
      end
      ST_GEN_CHK: begin
        acc_r <= ACC_W'(grate_r[idx_r]) * ACC_W'(delta_r) + ACC_W'(mrem_r[idx_r]);
      end
      ST_FLOW_CHK: begin
        d_r  <= pls_r[idx_r] - rcnt_r[idx_r];
        el_r <= elapsed;
      end
      ST_FLOW_MUL: begin
        num_r <= NUM_W'(d_r) * NUM_W'(MS_PER_MIN);
        den_r <= NUM_W'(ppg_r) * NUM_W'(el_r);
      end
      ST_EMIT: begin
        if (out_free && multi_r && !last_sensor) idx_r <= idx_r + IDX_W'(1);
      end
      default: acc_r <= acc_r;
    endcase
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r    <= kind_r;
      out_sensor_id_r <= idx_r;
      out_last_r      <= (kind_r != STAT_DONE) || !multi_r || last_sensor;
      if (kind_r == STAT_DONE) begin
        out_temp_r  <= temp_r[idx_r];
        out_vres_r  <= vld_r[idx_r];
        out_meter_r <= mtr_r[idx_r];
        out_pulse_r <= pls_r[idx_r];
        out_rate_r  <= rate_r[idx_r];
        out_gal_r   <= gal_r[idx_r];
        out_time_r  <= stamp_r[idx_r];
      end else begin
        out_temp_r  <= '0;
        out_vres_r  <= 1'b0;
        out_meter_r <= 1'b0;
        out_pulse_r <= '0;
        out_rate_r  <= '0;
        out_gal_r   <= '0;
        out_time_r  <= (kind_r == STAT_RANGE) ? now_r : '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_sensor_id     = out_sensor_id_r;
  assign out_temp_out      = out_temp_r;
  assign out_valid_res     = out_vres_r;
  assign out_is_meter      = out_meter_r;
  assign out_pulse_total   = out_pulse_r;
  assign out_flow_rate     = out_rate_r;
  assign out_total_gallons = out_gal_r;
  assign out_update_time   = out_time_r;
  assign out_last          = out_last_r;

  // divider finishes only while the sequencer waits on it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_GEN_WAIT || state_r == ST_GAL_WAIT ||
                      state_r == ST_RATE_WAIT))
    else $error("divider done outside a wait state");

  // divider is never restarted while busy
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // an accepted item is decoded on the next cycle
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DISPATCH))
    else $error("accepted item not dispatched");

  // a zero-delta beat is always the final one and carries no record
  a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_ZERO) |-> (out_last && out_pulse_total == '0))
    else $error("zero-delta beat malformed");

endmodule

@@ sv/pfm_div.sv @@
// pfm_div: bit-serial restoring divider, one quotient bit per cycle
// depends on pfm_pkg for operand widths and request/response structs
`timescale 1ns / 1ps

module pfm_div (
  input  logic             clk,
  input  logic             rst_n,
  input  pfm_pkg::div_req_t req,
  output pfm_pkg::div_rsp_t rsp
);
  import pfm_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;
  logic [DVS_W-1:0]  rem_nxt;

  // one restoring step: shift in next dividend bit, subtract when it fits
  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

@@ verif/pulse_flow_meter_with_rate_generator_unit_test.sv @@
// self-checking testbench for the pulse flow meter unit: directed table, then random beats
// depends on pfm_pkg and pulse_flow_meter_with_rate_generator_unit
`timescale 1ns / 1ps

module pulse_flow_meter_with_rate_generator_unit_test;
  import pfm_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic [1:0]  status;
    logic        sensor_id;
    logic [15:0] temp_out;
    logic        valid_res;
    logic        is_meter;
    logic [31:0] pulse_total;
    logic [31:0] flow_rate;
    logic [47:0] total_gallons;
    logic [31:0] update_time;
    logic        last;
  } meter_rec_t;

  typedef struct {
    cmd_t        cmd;
    logic        sensor;
    logic        all;
    logic [31:0] value;
    logic [15:0] temp;
    logic        fixed;
    meter_rec_t  want;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [3:0] in_cmd = '0;
  logic in_sensor = 0;
  logic in_all_sensors = 0;
  logic [31:0] in_value = '0;
  logic signed [15:0] in_temperature = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic out_sensor_id;
  logic signed [15:0] out_temp_out;
  logic out_valid_res;
  logic out_is_meter;
  logic [31:0] out_pulse_total;
  logic [31:0] out_flow_rate;
  logic [47:0] out_total_gallons;
  logic [31:0] out_update_time;
  logic out_last;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pulse_flow_meter_with_rate_generator_unit dut (.*);

  always #5 clk = ~clk;

  // predictor copy of configuration and records
  logic [1:0]  p_enable;
  logic signed [15:0] p_min_t, p_max_t;
  logic [15:0] p_ppg;
  logic [31:0] p_now;
  logic signed [15:0] p_temp [2];
  logic        p_valid [2];
  logic        p_meter [2];
  logic [31:0] p_pulses [2];
  logic [31:0] p_rate [2];
  logic [47:0] p_gal [2];
  logic [31:0] p_stamp [2];
  logic        p_gen_on [2];
  logic [23:0] p_gen_rate [2];
  logic [9:0]  p_milli [2];
  logic [31:0] p_ref_cnt [2];
  logic [31:0] p_ref_time [2];

  meter_rec_t expected_recs[$];
  int errors = 0;
  int cycles = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void clear_records();
    p_now = 0;
    for (int i = 0; i < 2; i++) begin
      p_temp[i] = TEMP_DEFAULT; p_valid[i] = 1; p_meter[i] = 0; p_pulses[i] = 0;
      p_rate[i] = 0; p_gal[i] = 0; p_stamp[i] = 0; p_gen_on[i] = 0; p_gen_rate[i] = 0;
      p_milli[i] = 0; p_ref_cnt[i] = 0; p_ref_time[i] = 0;
    end
  endfunction

  function automatic int present();
    return int'(p_enable[0]) + int'(p_enable[1]);
  endfunction

  function automatic void flow_update(int i);
    logic [31:0] el, d;
    logic [63:0] g, r, den, sum;
    if (!p_meter[i]) return;
    if (p_ppg == 0) begin
      p_rate[i] = 0;
      return;
    end
    el = p_now - p_ref_time[i];
    if (el == 0) return;
    d = p_pulses[i] - p_ref_cnt[i];
    g = {16'd0, d, 16'd0} / p_ppg;
    sum = {16'd0, p_gal[i]} + g;
    p_gal[i] = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
    den = 64'(p_ppg) * 64'(el);
    r = ((64'(d) * 64'd60000) << 16) / den;
    p_rate[i] = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    p_ref_cnt[i] = p_pulses[i];
    p_ref_time[i] = p_now;
  endfunction

  function automatic meter_rec_t record_of(int i, logic lst);
    meter_rec_t m;
    m = '0;
    m.status = STAT_DONE; m.sensor_id = i[0]; m.temp_out = p_temp[i];
    m.valid_res = p_valid[i]; m.is_meter = p_meter[i]; m.pulse_total = p_pulses[i];
    m.flow_rate = p_rate[i]; m.total_gallons = p_gal[i]; m.update_time = p_stamp[i];
    m.last = lst;
    return m;
  endfunction

  function automatic meter_rec_t range_rec(logic s);
    meter_rec_t m;
    m = '0;
    m.status = STAT_RANGE; m.sensor_id = s; m.update_time = p_now; m.last = 1;
    return m;
  endfunction

  function automatic void reset_flow(int i);
    p_rate[i] = 0; p_gal[i] = 0; p_ref_cnt[i] = p_pulses[i]; p_ref_time[i] = p_now;
  endfunction

  function automatic void push_all();
    int n;
    n = present();
    if (n == 0) expected_recs.push_back(range_rec(0));
    for (int i = 0; i < n; i++) expected_recs.push_back(record_of(i, i + 1 == n));
  endfunction

  // advance the predicted records by one command and queue its results
  function automatic void predict_meter(logic [3:0] cmd, logic s, logic all,
                                        logic [31:0] value, logic signed [15:0] t);
    int n;
    logic [63:0] acc, whole;
    logic [15:0] delta;
    meter_rec_t z;
    n = present();
    if (cmd == CMD_TICK) begin
      if (value == 0) begin
        z = '0; z.status = STAT_ZERO; z.last = 1;
        expected_recs.push_back(z);
        return;
      end
      delta = (value > 32'hFFFF) ? 16'hFFFF : value[15:0];
      p_now = p_now + delta;
      for (int i = 0; i < n; i++) if (p_gen_on[i]) begin
        acc = 64'(p_gen_rate[i]) * 64'(delta) + 64'(p_milli[i]);
        whole = acc / 1000;
        p_milli[i] = 10'(acc % 1000);
        if (whole > 0) begin
          p_pulses[i] += whole[31:0]; p_stamp[i] = p_now; flow_update(i);
        end
      end
      push_all();
      return;
    end
    if (cmd == CMD_RESET_FLOW && all) begin
      for (int i = 0; i < n; i++) reset_flow(i);
      push_all();
      return;
    end
    if (int'(s) >= n) begin
      expected_recs.push_back(range_rec(s));
      return;
    end
    case (cmd)
      CMD_SET_TEMP: begin
        if (t > p_max_t) t = p_max_t;
        if (t < p_min_t) t = p_min_t;
        p_temp[s] = t; p_stamp[s] = p_now;
      end
      CMD_SET_COUNT: begin
        p_pulses[s] = value; p_stamp[s] = p_now; p_ref_cnt[s] = value;
        p_ref_time[s] = p_now; p_rate[s] = 0;
      end
      CMD_ADD_PULSES: begin
        p_pulses[s] += value; p_stamp[s] = p_now; flow_update(s);
      end
      CMD_START_GEN: begin
        p_gen_on[s] = 1; p_gen_rate[s] = (value > 32'hFF_FFFF) ? 24'hFF_FFFF : value[23:0];
      end
      CMD_STOP_GEN: begin
        p_gen_on[s] = 0; p_gen_rate[s] = 0; p_milli[s] = 0;
      end
      CMD_SET_TYPE: begin
        p_meter[s] = value != 0; p_stamp[s] = p_now;
      end
      CMD_FAIL: begin
        p_valid[s] = 0; p_stamp[s] = p_now;
      end
      CMD_RECOVER: begin
        p_valid[s] = 1; p_stamp[s] = p_now;
      end
      CMD_RESET_FLOW: reset_flow(s);
      default: ;
    endcase
    expected_recs.push_back(record_of(s, 1));
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall pattern: random phases of busy and free
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    meter_rec_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_recs.size() == 0) begin
        report_mismatch("unexpected beat", out_status, 0);
      end else begin
        w = expected_recs.pop_front();
        if (out_status != w.status) report_mismatch("status", out_status, w.status);
        if (out_sensor_id != w.sensor_id) report_mismatch("sensor_id", out_sensor_id, w.sensor_id);
        if (out_temp_out != w.temp_out) report_mismatch("temp_out", out_temp_out, w.temp_out);
        if (out_valid_res != w.valid_res) report_mismatch("valid_res", out_valid_res, w.valid_res);
        if (out_is_meter != w.is_meter) report_mismatch("is_meter", out_is_meter, w.is_meter);
        if (out_pulse_total != w.pulse_total)
          report_mismatch("pulse_total", out_pulse_total, w.pulse_total);
        if (out_flow_rate != w.flow_rate) report_mismatch("flow_rate", out_flow_rate, w.flow_rate);
        if (out_total_gallons != w.total_gallons)
          report_mismatch("total_gallons", out_total_gallons, w.total_gallons);
        if (out_update_time != w.update_time)
          report_mismatch("update_time", out_update_time, w.update_time);
        if (out_last != w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  int burst_left = 0;

  // send one beat with burst/gap pacing; predictor runs at acceptance
  // valid stays up between beats of a burst and drops on a gap or a drain
  task automatic send_beat(logic [3:0] cmd, logic s, logic all, logic [31:0] v, logic [15:0] t);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1; in_cmd <= cmd; in_sensor <= s; in_all_sensors <= all;
    in_value <= v; in_temperature <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_meter(cmd, s, all, v, t);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_ENABLE:   p_enable = data[1:0];
      CFG_MIN_TEMP: p_min_t = data;
      CFG_MAX_TEMP: p_max_t = data;
      default:      p_ppg = data;
    endcase
    clear_records();
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  // random phase: mostly meter flows with generators and ticks
  task automatic random_phase(int count);
    logic [3:0] c;
    for (int k = 0; k < count; k++) begin
      c = ($urandom_range(0, 9) < 3) ? CMD_TICK : 4'($urandom_range(0, 15));
      send_beat(c, $urandom_range(0, 1), ($urandom_range(0, 3) == 0),
                (c == CMD_TICK && $urandom_range(0, 15) != 0) ? 32'($urandom_range(1, 2000))
                                                              : rand_value(),
                16'($urandom()));
      if (k == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    meter_rec_t z;
    p_enable = ENABLE_RST; p_min_t = MIN_TEMP_RST; p_max_t = MAX_TEMP_RST; p_ppg = PPG_RST;
    clear_records();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table: fixed rows carry a typed-in result
    z = '0; z.status = STAT_ZERO; z.last = 1;
    rows.push_back('{CMD_TICK, 0, 0, 32'd0, 16'd0, 1, z});
    z = '0; z.temp_out = TEMP_DEFAULT; z.valid_res = 1; z.last = 1;
    rows.push_back('{CMD_READ, 0, 0, 32'd0, 16'd0, 1, z});
    rows.push_back('{CMD_SET_TEMP, 0, 0, 0, 16'h7FFF, 0, '0});
    rows.push_back('{CMD_SET_TEMP, 1, 0, 0, 16'h8000, 0, '0});
    rows.push_back('{CMD_SET_TYPE, 0, 0, 32'd1, 0, 0, '0});
    rows.push_back('{CMD_SET_TYPE, 1, 0, 32'h8000_0000, 0, 0, '0});
    rows.push_back('{CMD_SET_COUNT, 0, 0, 32'hFFFF_FFF0, 0, 0, '0});
    rows.push_back('{CMD_TICK, 0, 0, 32'hFFFF_FFFF, 0, 0, '0});
    rows.push_back('{CMD_ADD_PULSES, 0, 0, 32'd100, 0, 0, '0});
    rows.push_back('{CMD_START_GEN, 0, 0, 32'hFFFF_FFFF, 0, 0, '0});
    rows.push_back('{CMD_START_GEN, 1, 0, 32'd7, 0, 0, '0});
    rows.push_back('{CMD_TICK, 0, 0, 32'd333, 0, 0, '0});
    rows.push_back('{CMD_TICK, 0, 0, 32'd1, 0, 0, '0});
    rows.push_back('{CMD_STOP_GEN, 0, 0, 0, 0, 0, '0});
    rows.push_back('{CMD_FAIL, 1, 0, 0, 0, 0, '0});
    rows.push_back('{CMD_RECOVER, 1, 0, 0, 0, 0, '0});
    rows.push_back('{CMD_RESET_FLOW, 0, 0, 0, 0, 0, '0});
    rows.push_back('{CMD_RESET_FLOW, 1, 1, 0, 0, 0, '0});
    rows.push_back('{cmd_t'(4'd15), 1, 0, 0, 0, 0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      if (r.fixed) begin
        if (expected_recs.size() != 0) drain();
        send_beat(r.cmd, r.sensor, r.all, r.value, r.temp);
        void'(expected_recs.pop_back());
        expected_recs.push_back(r.want);
      end else begin
        send_beat(r.cmd, r.sensor, r.all, r.value, r.temp);
      end
    end
    drain();

    // index out of range with one sensor, then none present
    write_reg(CFG_ENABLE, 16'd1);
    send_beat(CMD_READ, 1, 0, 0, 0);
    send_beat(CMD_TICK, 0, 0, 32'd5, 0);
    drain();
    write_reg(CFG_ENABLE, 16'd0);
    send_beat(CMD_TICK, 0, 0, 32'd9, 0);
    send_beat(CMD_RESET_FLOW, 0, 1, 0, 0);
    send_beat(CMD_SET_TEMP, 0, 0, 0, 16'd5);
    drain();

    // random phases over several register settings
    write_reg(CFG_ENABLE, 16'd3);
    write_reg(CFG_MIN_TEMP, 16'h8000);
    write_reg(CFG_MAX_TEMP, 16'h7FFF);
    write_reg(CFG_PPG, 16'd1);
    random_phase(200);
    write_reg(CFG_PPG, 16'hFFFF);
    write_reg(CFG_MIN_TEMP, 16'd1000);
    write_reg(CFG_MAX_TEMP, 16'hFC00);
    random_phase(200);
    write_reg(CFG_PPG, 16'd0);
    write_reg(CFG_ENABLE, 16'd2);
    random_phase(150);
    write_reg(CFG_ENABLE, 16'd3);
    write_reg(CFG_PPG, 16'($urandom_range(1, 2000)));
    write_reg(CFG_MIN_TEMP, MIN_TEMP_RST);
    write_reg(CFG_MAX_TEMP, MAX_TEMP_RST);
    random_phase(450);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pfm_pkg.sv
sv/pfm_div.sv
sv/pulse_flow_meter_with_rate_generator_unit.sv
verif/pulse_flow_meter_with_rate_generator_unit_test.sv
